/* src/dpj_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpj_pkg
// Shared types, constants and fixed-point helpers of the defocus position
// Jacobian block.
// ----------------------------------------------------------------------------
package dpj_pkg;

	localparam int DATA_W     = 32;
	localparam int FRAC_BITS  = 16;
	localparam int NUM_PARAMS = 9;
	localparam int IDX_W      = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int NUM_W      = DATA_W + 1;
	localparam int DEN_W      = DATA_W + 2;
	localparam int PROD_W     = 2 * DATA_W;
	localparam int RND_W      = PROD_W + 1;
	localparam int WIDE_W     = PROD_W + 2;
	localparam int DIV_LAT    = DATA_W + 2;

	typedef logic signed [DATA_W-1:0] q_t;
	typedef logic signed [NUM_W-1:0]  num_t;
	typedef logic signed [DEN_W-1:0]  den_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [RND_W-1:0]  rnd_t;
	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

	localparam q_t   QMAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam q_t   QMIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam q_t   ONE  = q_t'(64'sd1 <<< FRAC_BITS);
	localparam rnd_t HALF = rnd_t'(64'sd1 <<< (FRAC_BITS - 1));

	localparam cfg_idx_t REG_COMA_X  = 3'd0;
	localparam cfg_idx_t REG_COMA_Y  = 3'd1;
	localparam cfg_idx_t REG_ASTIG_X = 3'd2;
	localparam cfg_idx_t REG_ASTIG_Y = 3'd3;
	localparam cfg_idx_t REG_DEFOCUS = 3'd4;

	localparam idx_t PRM_COMA_X     = 4'd1;
	localparam idx_t PRM_COMA_Y     = 4'd2;
	localparam idx_t PRM_ASTIG_X    = 4'd3;
	localparam idx_t PRM_ASTIG_Y    = 4'd4;
	localparam idx_t PRM_TILT_X     = 4'd5;
	localparam idx_t PRM_TILT_Y     = 4'd6;
	localparam idx_t PRM_DEFOCUS    = 4'd7;
	localparam idx_t PRM_FLUX       = 4'd8;
	localparam idx_t PRM_BACKGROUND = 4'd9;

	typedef struct packed {
		logic ovf;
		q_t   val;
	} sat_t;

	typedef struct packed {
		idx_t k;
		logic dzero;
		logic ovf;
		q_t   x;
		q_t   y;
		q_t   h00;
		q_t   h01;
		q_t   h10;
		q_t   h11;
		q_t   xy;
		q_t   sq1;
		q_t   sq2;
		q_t   ax_x;
		q_t   ay_y;
		q_t   ay_x;
		q_t   ax_y;
	} pay_t;

	function automatic wide_t ext(input q_t a);
		return wide_t'(a);
	endfunction

	function automatic wide_t rnd(input prod_t p);
		rnd_t t;
		t = rnd_t'(p) + HALF;
		return wide_t'(t >>> FRAC_BITS);
	endfunction

	function automatic sat_t sat(input wide_t v);
		sat_t r;
		if (v > ext(QMAX)) begin
			r.ovf = 1'b1;
			r.val = QMAX;
		end else if (v < ext(QMIN)) begin
			r.ovf = 1'b1;
			r.val = QMIN;
		end else begin
			r.ovf = 1'b0;
			r.val = v[DATA_W-1:0];
		end
		return r;
	endfunction

	function automatic num_t to_num(input q_t a);
		return num_t'(a);
	endfunction

	function automatic num_t neg_num(input q_t a);
		return -num_t'(a);
	endfunction

	function automatic den_t to_den(input q_t a);
		return den_t'(a);
	endfunction

endpackage

/* src/dpj_div2.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpj_div2
// Two-lane pipelined fixed-point divider, one quotient bit per stage:
// q = sat((num * 2^FRAC_BITS) / den), truncated toward zero. Carries the
// item payload and valid bit alongside.
// ----------------------------------------------------------------------------
module dpj_div2 (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  dpj_pkg::pay_t in_pay,
	input  dpj_pkg::num_t num0,
	input  dpj_pkg::den_t den0,
	input  dpj_pkg::num_t num1,
	input  dpj_pkg::den_t den1,
	output logic          out_valid,
	output dpj_pkg::pay_t out_pay,
	output dpj_pkg::q_t   q0,
	output dpj_pkg::q_t   q1,
	output logic          ovf0,
	output logic          ovf1
);

	localparam int STG  = dpj_pkg::DATA_W;
	localparam int NN_W = dpj_pkg::NUM_W + dpj_pkg::FRAC_BITS;
	localparam int DW   = dpj_pkg::DATA_W;
	localparam int EW   = dpj_pkg::DEN_W;

	logic          val_s [0:STG];
	dpj_pkg::pay_t pay_s [0:STG];
	dpj_pkg::num_t num_a [2];
	dpj_pkg::den_t den_a [2];

	assign num_a[0] = num0;
	assign num_a[1] = num1;
	assign den_a[0] = den0;
	assign den_a[1] = den1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= STG; i++) val_s[i] <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			val_s[0] <= in_valid;
			for (int i = 0; i < STG; i++) val_s[i+1] <= val_s[i];
			out_valid <= val_s[STG];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s[0] <= in_pay;
			for (int i = 0; i < STG; i++) pay_s[i+1] <= pay_s[i];
			out_pay <= pay_s[STG];
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic [EW-1:0] rem_s  [0:STG];
		logic [EW-1:0] dn_s   [0:STG];
		logic [DW-1:0] low_s  [0:STG];
		logic [DW-1:0] quo_s  [0:STG];
		logic          neg_s  [0:STG];
		logic          big_s  [0:STG];
		logic [EW:0]   t_c    [STG];
		logic [EW:0]   diff_c [STG];
		logic          ge_c   [STG];
		logic [dpj_pkg::NUM_W-1:0] an;
		logic [EW-1:0]             dn;
		logic [NN_W-1:0]           nn;
		logic [NN_W-DW-1:0]        hi;
		logic [DW-1:0]             qm;
		dpj_pkg::q_t               res_q;
		logic                      ovf_q;

		assign an = num_a[l][dpj_pkg::NUM_W-1] ? dpj_pkg::NUM_W'(-num_a[l])
			: dpj_pkg::NUM_W'(num_a[l]);
		assign dn = den_a[l][EW-1] ? EW'(-den_a[l]) : EW'(den_a[l]);
		assign nn = {an, {dpj_pkg::FRAC_BITS{1'b0}}};
		assign hi = nn[NN_W-1:DW];

		always_comb begin
			for (int j = 0; j < STG; j++) begin
				t_c[j]    = {rem_s[j], low_s[j][DW-1-j]};
				diff_c[j] = t_c[j] - {1'b0, dn_s[j]};
				ge_c[j]   = t_c[j] >= {1'b0, dn_s[j]};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[0] <= EW'(hi);
				dn_s[0]  <= dn;
				low_s[0] <= nn[DW-1:0];
				quo_s[0] <= '0;
				neg_s[0] <= num_a[l][dpj_pkg::NUM_W-1] ^ den_a[l][EW-1];
				big_s[0] <= EW'(hi) >= dn;
				for (int j = 0; j < STG; j++) begin
					rem_s[j+1] <= ge_c[j] ? diff_c[j][EW-1:0] : t_c[j][EW-1:0];
					quo_s[j+1] <= {quo_s[j][DW-2:0], ge_c[j]};
					dn_s[j+1]  <= dn_s[j];
					low_s[j+1] <= low_s[j];
					neg_s[j+1] <= neg_s[j];
					big_s[j+1] <= big_s[j];
				end
			end
		end

		assign qm = quo_s[STG];

		always_ff @(posedge clk) begin
			if (en) begin
				if (!neg_s[STG]) begin
					if (big_s[STG] || qm[DW-1]) begin
						res_q <= dpj_pkg::QMAX;
						ovf_q <= 1'b1;
					end else begin
						res_q <= dpj_pkg::q_t'(qm);
						ovf_q <= 1'b0;
					end
				end else begin
					if (big_s[STG] || qm > dpj_pkg::QMIN) begin
						res_q <= dpj_pkg::QMIN;
						ovf_q <= 1'b1;
					end else begin
						res_q <= dpj_pkg::q_t'(~qm + 1'b1);
						ovf_q <= 1'b0;
					end
				end
			end
		end
	end

	assign q0   = g_lane[0].res_q;
	assign q1   = g_lane[1].res_q;
	assign ovf0 = g_lane[0].ovf_q;
	assign ovf1 = g_lane[1].ovf_q;

endmodule

/* src/defocus_position_jacobian.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// defocus_position_jacobian
// Per point, emits the x/y position partials for parameters 1 to 9 from a
// parameter vector built of position powers and defocus divisions, times
// the point's 2x2 inverse Hessian. Signed Q16.16, saturating.
// ----------------------------------------------------------------------------
// channel   dir  handshake               payload
// s_axis    in   tvalid/tready           tdata: x_pos..inv_hessian_11
// m_axis    out  tvalid/tready           tdata: grad_x, grad_y; tuser; tlast
// cfg       in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
// Nine results per point, one per cycle while m_axis does not stall. The
// path from issue to result runs through three 34-stage pipelined dividers
// in series. Reset clears all valid bits and loads the coefficients
// (defocus 1.0). A stall on m_axis freezes the whole pipeline; nothing is
// dropped or repeated.
// ----------------------------------------------------------------------------
module defocus_position_jacobian (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// x_pos, y_pos, inv_hessian_00, inv_hessian_01, inv_hessian_10, inv_hessian_11
	input  logic [6*dpj_pkg::DATA_W-1:0]    s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// grad_x, grad_y
	output logic [2*dpj_pkg::DATA_W-1:0]    m_axis_tdata,
	// param_index, overflow_flag
	output logic [dpj_pkg::IDX_W:0]         m_axis_tuser,
	output logic                            m_axis_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  dpj_pkg::cfg_idx_t               cfg_index,
	input  logic [dpj_pkg::DATA_W-1:0]      cfg_data
);

	localparam int DW = dpj_pkg::DATA_W;

	dpj_pkg::q_t   cx_q, cy_q, ax_q, ay_q, d_q;
	dpj_pkg::idx_t cnt_q;
	dpj_pkg::q_t   x_q, y_q, h00_q, h01_q, h10_q, h11_q;
	logic          en, issue;

	dpj_pkg::pay_t pay_s1, pay_s2, pay_s3, pay_s4, pay_s5, pay_s6, pay_s7;
	dpj_pkg::pay_t pay_s8, pay_s9, pay_s10, pay_s11;
	dpj_pkg::pay_t nx1, nx2, nx3, nx4, nx5, nx6, nx7, nx8, nx9, nx10, nx11;
	logic val_s1, val_s2, val_s3, val_s4, val_s5, val_s6, val_s7;
	logic val_s8, val_s9, val_s10, val_s11, val_s12;

	dpj_pkg::prod_t pxx_s2, pyy_s2, pxy_s2;
	dpj_pkg::q_t    xx_s3, yy_s3;
	dpj_pkg::prod_t p5_s5 [8];
	dpj_pkg::q_t    m_s6 [4];
	dpj_pkg::q_t    r0_s7, r1_s7;
	dpj_pkg::num_t  n0_s8, n1_s8, n0_s9, n1_s9;
	dpj_pkg::den_t  e0_s8, e1_s8, e0_s9, e1_s9;
	dpj_pkg::q_t    v0_s10, v1_s10;
	dpj_pkg::prod_t g00_s11, g01_s11, g10_s11, g11_s11;
	dpj_pkg::q_t    gx_s12, gy_s12;
	dpj_pkg::idx_t  k_s12;
	logic           ovf_s12;

	dpj_pkg::sat_t  xx_n, yy_n, xy_n, sq1_n, sq2_n, r0_n, r1_n, w0_n, w1_n, gx_n, gy_n;
	dpj_pkg::sat_t  m_n [8];
	dpj_pkg::num_t  dn0, dn1, n0_n, n1_n, n0_m, n1_m;
	dpj_pkg::den_t  de0, de1, e0_n, e1_n, e0_m, e1_m;
	dpj_pkg::den_t  d1, d2, d4, one_d;
	dpj_pkg::q_t    v0_n, v1_n;

	logic          d1_val, d2_val, d3_val;
	dpj_pkg::pay_t d1_pay, d2_pay, d3_pay;
	dpj_pkg::q_t   d1_q0, d1_q1, d2_q0, d2_q1, d3_q0, d3_q1;
	logic          d1_o0, d1_o1, d2_o0, d2_o1, d3_o0, d3_o1;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			ax_q <= '0;
			ay_q <= '0;
			d_q  <= dpj_pkg::ONE;
		end else if (cfg_valid) begin
			case (cfg_index)
				dpj_pkg::REG_COMA_X:  cx_q <= cfg_data;
				dpj_pkg::REG_COMA_Y:  cy_q <= cfg_data;
				dpj_pkg::REG_ASTIG_X: ax_q <= cfg_data;
				dpj_pkg::REG_ASTIG_Y: ay_q <= cfg_data;
				dpj_pkg::REG_DEFOCUS: d_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// issue: one parameter index per cycle from the held point, unless m_axis stalls
	assign en            = !val_s12 || m_axis_tready;
	assign issue         = en && (cnt_q != '0);
	assign s_axis_tready = (cnt_q == '0) || (en && cnt_q == dpj_pkg::PRM_BACKGROUND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			cnt_q <= dpj_pkg::PRM_COMA_X;
		end else if (issue) begin
			cnt_q <= (cnt_q == dpj_pkg::PRM_BACKGROUND) ? '0 : cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			x_q   <= s_axis_tdata[0*DW +: DW];
			y_q   <= s_axis_tdata[1*DW +: DW];
			h00_q <= s_axis_tdata[2*DW +: DW];
			h01_q <= s_axis_tdata[3*DW +: DW];
			h10_q <= s_axis_tdata[4*DW +: DW];
			h11_q <= s_axis_tdata[5*DW +: DW];
		end
	end

	// denominators
	assign d1    = dpj_pkg::to_den(d_q);
	assign d2    = d1 <<< 1;
	assign d4    = d1 <<< 2;
	assign one_d = dpj_pkg::to_den(dpj_pkg::ONE);

	// squares, sums, coefficient products
	always_comb begin
		nx1       = '0;
		nx1.k     = cnt_q;
		nx1.dzero = (d_q == '0);
		nx1.x     = x_q;
		nx1.y     = y_q;
		nx1.h00   = h00_q;
		nx1.h01   = h01_q;
		nx1.h10   = h10_q;
		nx1.h11   = h11_q;

		xx_n = dpj_pkg::sat(dpj_pkg::rnd(pxx_s2));
		yy_n = dpj_pkg::sat(dpj_pkg::rnd(pyy_s2));
		xy_n = dpj_pkg::sat(dpj_pkg::rnd(pxy_s2));
		nx2  = pay_s1;
		nx3  = pay_s2;
		nx3.xy = xy_n.val;
		if (pay_s2.k inside {[dpj_pkg::PRM_COMA_X:dpj_pkg::PRM_DEFOCUS]})
			nx3.ovf = pay_s2.ovf | xx_n.ovf | yy_n.ovf | xy_n.ovf;

		sq1_n = dpj_pkg::sat((dpj_pkg::ext(xx_s3) <<< 1) + dpj_pkg::ext(xx_s3)
			+ dpj_pkg::ext(yy_s3));
		sq2_n = dpj_pkg::sat(dpj_pkg::ext(xx_s3) + (dpj_pkg::ext(yy_s3) <<< 1)
			+ dpj_pkg::ext(yy_s3));
		nx4     = pay_s3;
		nx4.sq1 = sq1_n.val;
		nx4.sq2 = sq2_n.val;
		if (pay_s3.k inside {[dpj_pkg::PRM_COMA_X:dpj_pkg::PRM_DEFOCUS]})
			nx4.ovf = pay_s3.ovf | sq1_n.ovf | sq2_n.ovf;

		nx5 = pay_s4;

		for (int i = 0; i < 8; i++) m_n[i] = dpj_pkg::sat(dpj_pkg::rnd(p5_s5[i]));
		nx6      = pay_s5;
		nx6.ax_x = m_n[4].val;
		nx6.ay_y = m_n[5].val;
		nx6.ay_x = m_n[6].val;
		nx6.ax_y = m_n[7].val;
		if (pay_s5.k == dpj_pkg::PRM_DEFOCUS)
			nx6.ovf = pay_s5.ovf | m_n[0].ovf | m_n[1].ovf | m_n[2].ovf | m_n[3].ovf
				| m_n[4].ovf | m_n[5].ovf | m_n[6].ovf | m_n[7].ovf;

		r0_n = dpj_pkg::sat(dpj_pkg::ext(m_s6[0]) + (dpj_pkg::ext(m_s6[1]) <<< 1));
		r1_n = dpj_pkg::sat(dpj_pkg::ext(m_s6[2]) + (dpj_pkg::ext(m_s6[3]) <<< 1));
		nx7  = pay_s6;
		if (pay_s6.k == dpj_pkg::PRM_DEFOCUS)
			nx7.ovf = pay_s6.ovf | r0_n.ovf | r1_n.ovf;
	end

	// first division operands
	always_comb begin
		dn0 = '0;
		dn1 = '0;
		de0 = one_d;
		de1 = one_d;
		case (pay_s7.k)
			dpj_pkg::PRM_COMA_X: begin
				dn0 = dpj_pkg::to_num(pay_s7.sq1);
				dn1 = dpj_pkg::to_num(pay_s7.xy);
				de0 = d1;
				de1 = d1;
			end
			dpj_pkg::PRM_COMA_Y: begin
				dn0 = dpj_pkg::to_num(pay_s7.xy);
				dn1 = dpj_pkg::to_num(pay_s7.sq2);
				de0 = d1;
				de1 = d1;
			end
			dpj_pkg::PRM_ASTIG_X: begin
				dn0 = dpj_pkg::neg_num(pay_s7.x);
				dn1 = dpj_pkg::to_num(pay_s7.y);
				de0 = d1;
				de1 = d1;
			end
			dpj_pkg::PRM_ASTIG_Y: begin
				dn0 = dpj_pkg::neg_num(pay_s7.y);
				dn1 = dpj_pkg::neg_num(pay_s7.x);
				de0 = d1;
				de1 = d1;
			end
			dpj_pkg::PRM_DEFOCUS: begin
				dn0 = dpj_pkg::to_num(r0_s7);
				dn1 = dpj_pkg::to_num(r1_s7);
				de0 = d2;
				de1 = d2;
			end
			default: ;
		endcase
	end

	dpj_div2 u_div1 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(val_s7), .in_pay(pay_s7),
		.num0(dn0), .den0(de0), .num1(dn1), .den1(de1),
		.out_valid(d1_val), .out_pay(d1_pay),
		.q0(d1_q0), .q1(d1_q1), .ovf0(d1_o0), .ovf1(d1_o1)
	);

	// second division operands
	always_comb begin
		w0_n = dpj_pkg::sat(dpj_pkg::ext(d1_q0) + dpj_pkg::ext(d1_pay.ax_x)
			+ dpj_pkg::ext(d1_pay.ay_y));
		w1_n = dpj_pkg::sat(dpj_pkg::ext(d1_q1) + dpj_pkg::ext(d1_pay.ay_x)
			- dpj_pkg::ext(d1_pay.ax_y));
		nx8  = d1_pay;
		if (d1_pay.k inside {dpj_pkg::PRM_COMA_X, dpj_pkg::PRM_COMA_Y, dpj_pkg::PRM_ASTIG_X,
				dpj_pkg::PRM_ASTIG_Y, dpj_pkg::PRM_DEFOCUS})
			nx8.ovf = d1_pay.ovf | d1_o0 | d1_o1;
		n0_n = dpj_pkg::to_num(d1_q0);
		n1_n = dpj_pkg::to_num(d1_q1);
		e0_n = one_d;
		e1_n = one_d;
		case (d1_pay.k)
			dpj_pkg::PRM_COMA_X: begin
				n0_n = dpj_pkg::neg_num(d1_q0);
				n1_n = dpj_pkg::neg_num(d1_q1);
				e0_n = d4;
				e1_n = d2;
			end
			dpj_pkg::PRM_COMA_Y: begin
				n0_n = dpj_pkg::neg_num(d1_q0);
				n1_n = dpj_pkg::neg_num(d1_q1);
				e0_n = d2;
				e1_n = d4;
			end
			dpj_pkg::PRM_DEFOCUS: begin
				n0_n = dpj_pkg::to_num(w0_n.val);
				n1_n = dpj_pkg::to_num(w1_n.val);
				e0_n = d1;
				e1_n = d1;
				nx8.ovf = d1_pay.ovf | d1_o0 | d1_o1 | w0_n.ovf | w1_n.ovf;
			end
			default: ;
		endcase
	end

	dpj_div2 u_div2 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(val_s8), .in_pay(pay_s8),
		.num0(n0_s8), .den0(e0_s8), .num1(n1_s8), .den1(e1_s8),
		.out_valid(d2_val), .out_pay(d2_pay),
		.q0(d2_q0), .q1(d2_q1), .ovf0(d2_o0), .ovf1(d2_o1)
	);

	// third division operands
	always_comb begin
		nx9  = d2_pay;
		n0_m = dpj_pkg::to_num(d2_q0);
		n1_m = dpj_pkg::to_num(d2_q1);
		e0_m = one_d;
		e1_m = one_d;
		if (d2_pay.k inside {dpj_pkg::PRM_COMA_X, dpj_pkg::PRM_COMA_Y, dpj_pkg::PRM_DEFOCUS})
			nx9.ovf = d2_pay.ovf | d2_o0 | d2_o1;
		if (d2_pay.k == dpj_pkg::PRM_DEFOCUS) begin
			e0_m = d1;
			e1_m = d1;
		end
	end

	dpj_div2 u_div3 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(val_s9), .in_pay(pay_s9),
		.num0(n0_s9), .den0(e0_s9), .num1(n1_s9), .den1(e1_s9),
		.out_valid(d3_val), .out_pay(d3_pay),
		.q0(d3_q0), .q1(d3_q1), .ovf0(d3_o0), .ovf1(d3_o1)
	);

	// parameter vector, Hessian product, final sums
	always_comb begin
		nx10 = d3_pay;
		if (d3_pay.k == dpj_pkg::PRM_DEFOCUS)
			nx10.ovf = d3_pay.ovf | d3_o0 | d3_o1;
		case (d3_pay.k)
			dpj_pkg::PRM_TILT_X: begin
				v0_n = -dpj_pkg::ONE;
				v1_n = '0;
			end
			dpj_pkg::PRM_TILT_Y: begin
				v0_n = '0;
				v1_n = -dpj_pkg::ONE;
			end
			dpj_pkg::PRM_FLUX, dpj_pkg::PRM_BACKGROUND: begin
				v0_n = '0;
				v1_n = '0;
			end
			default: begin
				v0_n = d3_q0;
				v1_n = d3_q1;
			end
		endcase
		nx11 = pay_s10;
		gx_n = dpj_pkg::sat(dpj_pkg::rnd(g00_s11) + dpj_pkg::rnd(g01_s11));
		gy_n = dpj_pkg::sat(dpj_pkg::rnd(g10_s11) + dpj_pkg::rnd(g11_s11));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1  <= 1'b0;
			val_s2  <= 1'b0;
			val_s3  <= 1'b0;
			val_s4  <= 1'b0;
			val_s5  <= 1'b0;
			val_s6  <= 1'b0;
			val_s7  <= 1'b0;
			val_s8  <= 1'b0;
			val_s9  <= 1'b0;
			val_s10 <= 1'b0;
			val_s11 <= 1'b0;
			val_s12 <= 1'b0;
		end else if (en) begin
			val_s1  <= issue;
			val_s2  <= val_s1;
			val_s3  <= val_s2;
			val_s4  <= val_s3;
			val_s5  <= val_s4;
			val_s6  <= val_s5;
			val_s7  <= val_s6;
			val_s8  <= d1_val;
			val_s9  <= d2_val;
			val_s10 <= d3_val;
			val_s11 <= val_s10;
			val_s12 <= val_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s1 <= nx1;

			pay_s2 <= nx2;
			pxx_s2 <= pay_s1.x * pay_s1.x;
			pyy_s2 <= pay_s1.y * pay_s1.y;
			pxy_s2 <= pay_s1.x * pay_s1.y;

			pay_s3 <= nx3;
			xx_s3  <= xx_n.val;
			yy_s3  <= yy_n.val;

			pay_s4 <= nx4;

			pay_s5   <= nx5;
			p5_s5[0] <= cx_q * pay_s4.sq1;
			p5_s5[1] <= cy_q * pay_s4.xy;
			p5_s5[2] <= cy_q * pay_s4.sq2;
			p5_s5[3] <= cx_q * pay_s4.xy;
			p5_s5[4] <= ax_q * pay_s4.x;
			p5_s5[5] <= ay_q * pay_s4.y;
			p5_s5[6] <= ay_q * pay_s4.x;
			p5_s5[7] <= ax_q * pay_s4.y;

			pay_s6 <= nx6;
			for (int i = 0; i < 4; i++) m_s6[i] <= m_n[i].val;

			pay_s7 <= nx7;
			r0_s7  <= r0_n.val;
			r1_s7  <= r1_n.val;

			pay_s8 <= nx8;
			n0_s8  <= n0_n;
			n1_s8  <= n1_n;
			e0_s8  <= e0_n;
			e1_s8  <= e1_n;

			pay_s9 <= nx9;
			n0_s9  <= n0_m;
			n1_s9  <= n1_m;
			e0_s9  <= e0_m;
			e1_s9  <= e1_m;

			pay_s10 <= nx10;
			v0_s10  <= v0_n;
			v1_s10  <= v1_n;

			pay_s11 <= nx11;
			g00_s11 <= pay_s10.h00 * v0_s10;
			g01_s11 <= pay_s10.h01 * v1_s10;
			g10_s11 <= pay_s10.h10 * v0_s10;
			g11_s11 <= pay_s10.h11 * v1_s10;

			k_s12 <= pay_s11.k;
			if (pay_s11.k == dpj_pkg::PRM_FLUX || pay_s11.k == dpj_pkg::PRM_BACKGROUND) begin
				gx_s12  <= '0;
				gy_s12  <= '0;
				ovf_s12 <= 1'b0;
			end else if (pay_s11.dzero && pay_s11.k inside {dpj_pkg::PRM_COMA_X,
					dpj_pkg::PRM_COMA_Y, dpj_pkg::PRM_ASTIG_X, dpj_pkg::PRM_ASTIG_Y,
					dpj_pkg::PRM_DEFOCUS}) begin
				gx_s12  <= dpj_pkg::QMAX;
				gy_s12  <= dpj_pkg::QMAX;
				ovf_s12 <= 1'b1;
			end else begin
				gx_s12  <= gx_n.val;
				gy_s12  <= gy_n.val;
				ovf_s12 <= pay_s11.ovf | gx_n.ovf | gy_n.ovf;
			end
		end
	end

	assign m_axis_tvalid = val_s12;
	assign m_axis_tdata  = {gy_s12, gx_s12};
	assign m_axis_tuser  = {ovf_s12, k_s12};
	assign m_axis_tlast  = k_s12 == dpj_pkg::PRM_BACKGROUND;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= dpj_pkg::PRM_BACKGROUND)
		else $error("issue counter out of range");

	a_accept_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && cnt_q != '0) |-> cnt_q == dpj_pkg::PRM_BACKGROUND)
		else $error("point accepted while the previous one still issues");

	a_issue_order: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && cnt_q != dpj_pkg::PRM_BACKGROUND) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("parameter index skipped");

	a_flux_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (k_s12 == dpj_pkg::PRM_FLUX || k_s12 == dpj_pkg::PRM_BACKGROUND))
		|-> (m_axis_tdata == '0 && !ovf_s12))
		else $error("flux or background result not zero");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for defocus_position_jacobian. Points are streamed in
// with random gaps. Results are drained with random back-pressure. A
// Q16.16 Jacobian predictor computes the nine expected results per point.
// Coefficients are changed only while the block is drained: defaults,
// zero, extreme and random settings, plus writes to unused indexes.
// ----------------------------------------------------------------------------
module tb_top;

	class jacobian_scoreboard;
		typedef struct {
			dpj_pkg::idx_t k;
			logic [31:0]   gx;
			logic [31:0]   gy;
			logic          ovf;
			logic          last;
		} grad_t;

		longint cx, cy, ax, ay, d;
		bit     ovf;
		grad_t  grads_due[$];
		int     fails;

		function new();
			cx = 0; cy = 0; ax = 0; ay = 0; d = longint'(dpj_pkg::ONE);
			fails = 0;
		endfunction

		function void set_coeff(dpj_pkg::cfg_idx_t idx, logic [31:0] v);
			longint s;
			s = longint'(dpj_pkg::q_t'(v));
			case (idx)
				dpj_pkg::REG_COMA_X:  cx = s;
				dpj_pkg::REG_COMA_Y:  cy = s;
				dpj_pkg::REG_ASTIG_X: ax = s;
				dpj_pkg::REG_ASTIG_Y: ay = s;
				dpj_pkg::REG_DEFOCUS: d  = s;
				default: ;
			endcase
		endfunction

		function longint sat32(longint v);
			if (v > longint'(dpj_pkg::QMAX)) begin
				ovf = 1;
				return longint'(dpj_pkg::QMAX);
			end
			if (v < longint'(dpj_pkg::QMIN)) begin
				ovf = 1;
				return longint'(dpj_pkg::QMIN);
			end
			return v;
		endfunction

		function longint rshr(longint v);
			return (v + (64'sd1 <<< (dpj_pkg::FRAC_BITS - 1))) >>> dpj_pkg::FRAC_BITS;
		endfunction

		function longint mulq(longint a, longint b);
			return sat32(rshr(a * b));
		endfunction

		function longint divq(longint a, longint den);
			return sat32((a * (64'sd1 <<< dpj_pkg::FRAC_BITS)) / den);
		endfunction

		function void note_point(logic [6*dpj_pkg::DATA_W-1:0] td);
			longint x, y, h00, h01, h10, h11;
			longint v0, v1, gx, gy, xx, yy, xy, s1, s2, r, w;
			grad_t  g;
			x   = longint'(dpj_pkg::q_t'(td[31:0]));
			y   = longint'(dpj_pkg::q_t'(td[63:32]));
			h00 = longint'(dpj_pkg::q_t'(td[95:64]));
			h01 = longint'(dpj_pkg::q_t'(td[127:96]));
			h10 = longint'(dpj_pkg::q_t'(td[159:128]));
			h11 = longint'(dpj_pkg::q_t'(td[191:160]));
			for (int i = 1; i <= dpj_pkg::NUM_PARAMS; i++) begin
				g.k = dpj_pkg::idx_t'(i);
				ovf = 0;
				v0 = 0; v1 = 0; gx = 0; gy = 0;
				if (d == 0 && (g.k <= dpj_pkg::PRM_ASTIG_Y || g.k == dpj_pkg::PRM_DEFOCUS)) begin
					gx = longint'(dpj_pkg::QMAX);
					gy = longint'(dpj_pkg::QMAX);
					ovf = 1;
				end else if (g.k <= dpj_pkg::PRM_DEFOCUS) begin
					xx = mulq(x, x);
					yy = mulq(y, y);
					xy = mulq(x, y);
					s1 = sat32(3 * xx + yy);
					s2 = sat32(xx + 3 * yy);
					case (g.k)
						dpj_pkg::PRM_COMA_X: begin
							v0 = divq(-divq(s1, d), 4 * d);
							v1 = divq(-divq(xy, d), 2 * d);
						end
						dpj_pkg::PRM_COMA_Y: begin
							v0 = divq(-divq(xy, d), 2 * d);
							v1 = divq(-divq(s2, d), 4 * d);
						end
						dpj_pkg::PRM_ASTIG_X: begin
							v0 = divq(-x, d);
							v1 = divq(y, d);
						end
						dpj_pkg::PRM_ASTIG_Y: begin
							v0 = divq(-y, d);
							v1 = divq(-x, d);
						end
						dpj_pkg::PRM_TILT_X: v0 = -longint'(dpj_pkg::ONE);
						dpj_pkg::PRM_TILT_Y: v1 = -longint'(dpj_pkg::ONE);
						default: begin
							r  = sat32(mulq(cx, s1) + 2 * mulq(cy, xy));
							w  = sat32(divq(r, 2 * d) + mulq(ax, x) + mulq(ay, y));
							v0 = divq(divq(w, d), d);
							r  = sat32(mulq(cy, s2) + 2 * mulq(cx, xy));
							w  = sat32(divq(r, 2 * d) + mulq(ay, x) - mulq(ax, y));
							v1 = divq(divq(w, d), d);
						end
					endcase
					gx = sat32(rshr(h00 * v0) + rshr(h01 * v1));
					gy = sat32(rshr(h10 * v0) + rshr(h11 * v1));
				end
				g.gx   = gx[31:0];
				g.gy   = gy[31:0];
				g.ovf  = ovf;
				g.last = (i == dpj_pkg::NUM_PARAMS);
				grads_due.push_back(g);
			end
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			fails++;
		endtask

		task check_result(dpj_pkg::idx_t k, logic [31:0] gx, logic [31:0] gy, logic o,
			logic l);
			grad_t e;
			if (grads_due.size() == 0) begin
				report($sformatf("unexpected result index %0d", k));
				return;
			end
			e = grads_due.pop_front();
			if (k !== e.k)
				report($sformatf("index got %0d want %0d", k, e.k));
			if (gx !== e.gx)
				report($sformatf("k=%0d grad_x got %h want %h", e.k, gx, e.gx));
			if (gy !== e.gy)
				report($sformatf("k=%0d grad_y got %h want %h", e.k, gy, e.gy));
			if (o !== e.ovf)
				report($sformatf("k=%0d overflow got %b want %b", e.k, o, e.ovf));
			if (l !== e.last)
				report($sformatf("k=%0d last got %b want %b", e.k, l, e.last));
		endtask
	endclass

	logic                            clk = 0;
	logic                            arst_n = 0;
	logic                            s_axis_tvalid = 0;
	logic                            s_axis_tready;
	logic [6*dpj_pkg::DATA_W-1:0]    s_axis_tdata = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 0;
	logic [2*dpj_pkg::DATA_W-1:0]    m_axis_tdata;
	logic [dpj_pkg::IDX_W:0]         m_axis_tuser;
	logic                            m_axis_tlast;
	logic                            cfg_valid = 0;
	logic                            cfg_ready;
	dpj_pkg::cfg_idx_t               cfg_index = '0;
	logic [dpj_pkg::DATA_W-1:0]      cfg_data = '0;

	jacobian_scoreboard sb = new();
	bit  idle_mode = 1;
	int  drain_stall = 0;
	longint cycles = 0;

	defocus_position_jacobian DUT (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int draw_gap();
		if ($urandom_range(0, 63) == 0)
			idle_mode = ~idle_mode;
		return idle_mode ? $urandom_range(0, 14) : 0;
	endfunction

	function automatic logic [31:0] rand_q();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return dpj_pkg::QMAX;
			2: return dpj_pkg::QMIN;
			3: return 32'($urandom_range(0, 65535)) - 32'd32768;
			default: return {{12{1'b0}}, 20'($urandom)} ^ {32{$urandom_range(0, 1) == 1}};
		endcase
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_result(m_axis_tuser[dpj_pkg::IDX_W-1:0], m_axis_tdata[31:0],
					m_axis_tdata[63:32], m_axis_tuser[dpj_pkg::IDX_W], m_axis_tlast);
				drain_stall = draw_gap();
				if (drain_stall != 0)
					m_axis_tready <= 0;
			end else if (!m_axis_tready) begin
				if (drain_stall <= 1)
					m_axis_tready <= 1;
				else
					drain_stall--;
			end
		end
	end

	task automatic write_reg(dpj_pkg::cfg_idx_t idx, logic [31:0] v);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_coeff(idx, v);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] h00,
		logic [31:0] h01, logic [31:0] h10, logic [31:0] h11);
		int gap;
		gap = draw_gap();
		if (gap != 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata  <= {h11, h10, h01, h00, y, x};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_point({h11, h10, h01, h00, y, x});
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.grads_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_coeffs(logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
		logic [31:0] c3, logic [31:0] dd);
		write_reg(dpj_pkg::REG_COMA_X, c0);
		write_reg(dpj_pkg::REG_COMA_Y, c1);
		write_reg(dpj_pkg::REG_ASTIG_X, c2);
		write_reg(dpj_pkg::REG_ASTIG_Y, c3);
		write_reg(dpj_pkg::REG_DEFOCUS, dd);
	endtask

	initial begin
		logic [31:0] dsel;
		logic [31:0] one_v;
		logic [31:0] qmax_v;
		logic [31:0] qmin_v;
		one_v  = dpj_pkg::ONE;
		qmax_v = dpj_pkg::QMAX;
		qmin_v = dpj_pkg::QMIN;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset defaults, extreme positions, identity and extreme Hessians
		send_point(one_v, one_v, one_v, 0, 0, one_v);
		send_point(qmax_v, qmin_v, one_v, 0, 0, one_v);
		send_point(qmin_v, qmax_v, qmax_v, qmin_v, qmin_v, qmax_v);
		send_point(0, 0, qmax_v, qmax_v, qmax_v, qmax_v);
		send_point(32'hFFFF_FFFF, 32'h0002_8000, qmin_v, one_v, one_v, qmin_v);
		drain();

		set_coeffs(32'h0000_8000, 32'hFFFF_4000, 32'h0001_8000, 32'hFFFE_0000, 32'h0002_0000);
		write_reg(3'd5, $urandom);
		write_reg(3'd6, $urandom);
		write_reg(3'd7, $urandom);
		send_point(32'h0003_0000, 32'hFFFE_0000, one_v, 32'h0000_4000, 32'hFFFF_C000, one_v);
		send_point(qmax_v, qmax_v, one_v, one_v, one_v, one_v);
		send_point(32'h0000_0001, 32'hFFFF_FFFF, qmax_v, qmin_v, 0, one_v);
		drain();

		// zero defocus
		set_coeffs(qmax_v, qmin_v, qmax_v, qmin_v, 0);
		send_point(one_v, one_v, one_v, 0, 0, one_v);
		send_point(qmin_v, qmin_v, qmin_v, qmin_v, qmin_v, qmin_v);
		send_point(0, 0, qmax_v, 0, 0, qmax_v);
		drain();

		set_coeffs(qmin_v, qmax_v, qmin_v, qmax_v, qmin_v);
		send_point(qmax_v, qmin_v, one_v, one_v, one_v, one_v);
		send_point(one_v, one_v, qmax_v, qmax_v, qmax_v, qmax_v);
		drain();
		set_coeffs(0, 0, 0, 0, qmax_v);
		send_point(qmax_v, qmax_v, qmax_v, qmax_v, qmax_v, qmax_v);
		send_point(32'h0000_0001, 32'h0000_0001, one_v, 0, 0, one_v);
		drain();
		set_coeffs(one_v, one_v, one_v, one_v, 32'hFFFF_FFFF);
		send_point(one_v, 32'hFFFF_0000, one_v, 0, 0, one_v);
		send_point(qmin_v, 0, one_v, one_v, one_v, one_v);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			case ($urandom_range(0, 5))
				0: dsel = 0;
				1: dsel = one_v;
				2: dsel = 32'hFFFF_0000;
				3: dsel = $urandom;
				default: dsel = 32'($urandom_range(1, 1 << 20)) ^ {32{$urandom_range(0, 1) == 1}};
			endcase
			set_coeffs(rand_q(), rand_q(), rand_q(), rand_q(), dsel);
			if ($urandom_range(0, 2) == 0)
				write_reg(dpj_pkg::cfg_idx_t'($urandom_range(5, 7)), $urandom);
			for (int n = 0; n < 30; n++)
				send_point(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
			drain();
		end

		repeat (250) @(posedge clk);
		if (sb.fails == 0 && sb.grads_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
